/* rtl/best_fit_heap_allocator_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the best-fit heap allocator
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BFHA_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define BFHA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define BFHA_ASSERT(lbl, clk, rst_n, cond)
`define BFHA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* rtl/bfha_pkg.sv */
// ---------------------------------------------------------------------------
// bfha_pkg
// Types and constants shared by the allocator cells and the top level.
// ---------------------------------------------------------------------------
package bfha_pkg;

  localparam int HEAP_BYTES = 4096;
  localparam int OFF_W      = 12;
  localparam int LEN_W      = 13;
  localparam int ST_W       = 3;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE   = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [LEN_W-1:0] request_size;
    logic [OFF_W-1:0] block_offset;
  } bfha_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] granted_offset;
    logic [ST_W-1:0]  status;
  } bfha_out_t;

  typedef struct packed {
    logic             valid;
    logic             used;
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SPLIT,
    CMD_MARK,
    CMD_CLEAR,
    CMD_MERGE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [LEN_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic             action;
    logic [LEN_W-1:0] size;
    logic [OFF_W-1:0] offset;
  } scan_t;

  typedef struct packed {
    logic             found;
    logic             prev_free;
    logic             next_free;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] start;
  } tok_t;

endpackage

/* rtl/best_fit_heap_allocator_core.sv */
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_core
// Best-fit heap allocator over a row of segment cells, with coalescing.
// ---------------------------------------------------------------------------
// A request is taken only in idle; the token walks the whole row, then the edit
// step follows, which waits while an earlier result item is held by the receiver.
// The next request is taken only after the last one is done; a free that hits a
// segment also takes two merge steps (next, then previous).
// Reset (rst_n low, synchronous): one free segment covers the whole heap,
// segment count one, no result pending, input ready.
module best_fit_heap_allocator_core #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bfha_pkg::bfha_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bfha_pkg::bfha_out_t out_data
);
  import bfha_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_MERGE_NEXT, S_MERGE_PREV} state_t;

  state_t        state_r;
  scan_t         scan_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] count_r;
  tok_t          res_r;
  logic [IW-1:0] idx_r;
  logic          out_valid_r;
  bfha_out_t     out_r;

  cmd_t          cmd;
  logic [IW-1:0] cmd_idx;
  logic          go;
  logic          do_split;

  seg_t          seg_w     [MAX_SEGMENTS];
  tok_t          tok_w     [MAX_SEGMENTS+1];
  logic [IW-1:0] tok_idx_w [MAX_SEGMENTS+1];

  assign tok_w[0]     = '0;
  assign tok_idx_w[0] = '0;

  // Row of cells: the token walks one entry per cycle, edits are broadcast.
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    seg_t lft, rgt;
    if (i == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_l
      assign lft = seg_w[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_rn
      assign rgt = '0;
    end else begin : g_r
      assign rgt = seg_w[i+1];
    end
    bfha_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx),
      .scan        (scan_r),
      .left        (lft),
      .right       (rgt),
      .tok_in      (tok_w[i]),
      .tok_idx_in  (tok_idx_w[i]),
      .seg_q       (seg_w[i]),
      .tok_out     (tok_w[i+1]),
      .tok_idx_out (tok_idx_w[i+1])
    );
  end

  // hold the result stage while an earlier item waits to be taken
  assign go       = !(out_valid_r && out_stall);
  assign do_split = (state_r == S_EXEC) && go && (scan_r.action == ACT_ALLOC) &&
                    (scan_r.size != '0) && res_r.found && (res_r.len > scan_r.size) &&
                    (count_r != CW'(MAX_SEGMENTS));

  // Edit command to the row, derived from the current state.
  always_comb begin
    cmd      = '{op: CMD_NONE, size: scan_r.size};
    cmd_idx  = idx_r;
    case (state_r)
      S_EXEC: begin
        if (go && res_r.found) begin
          if (scan_r.action == ACT_FREE) begin
            cmd.op = CMD_CLEAR;
          end else if (scan_r.size != '0) begin
            if (res_r.len == scan_r.size) cmd.op = CMD_MARK;
            else if (do_split)            cmd.op = CMD_SPLIT;
          end
        end
      end
      S_MERGE_NEXT: if (res_r.next_free) cmd.op = CMD_MERGE;
      S_MERGE_PREV: begin
        cmd_idx = idx_r - 1'b1;
        if (res_r.prev_free) cmd.op = CMD_MERGE;
      end
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result; the result stage reloads it itself
      if (out_valid_r && !out_stall && (state_r != S_EXEC)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            scan_r.action <= in_data.action;
            scan_r.size   <= in_data.request_size;
            scan_r.offset <= in_data.block_offset;
            cnt_r         <= '0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // wait for the token to leave the last cell
          if (cnt_r == CW'(MAX_SEGMENTS)) begin
            res_r   <= tok_w[MAX_SEGMENTS];
            idx_r   <= tok_idx_w[MAX_SEGMENTS];
            state_r <= S_EXEC;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EXEC: begin
          if (go) begin
            out_valid_r <= 1'b1;
            if (scan_r.action == ACT_FREE) begin
              out_r.granted_offset <= '0;
              if (res_r.found) begin
                out_r.status <= ST_OK;
                state_r      <= S_MERGE_NEXT;
              end else begin
                out_r.status <= ST_NONE;
                state_r      <= S_IDLE;
              end
            end else if (scan_r.size == '0) begin
              out_r.granted_offset <= '0;
              out_r.status         <= ST_ZERO;
              state_r              <= S_IDLE;
            end else if (!res_r.found) begin
              out_r.granted_offset <= '0;
              out_r.status         <= ST_NO_FIT;
              state_r              <= S_IDLE;
            end else if ((res_r.len > scan_r.size) && !do_split) begin
              out_r.granted_offset <= '0;
              out_r.status         <= ST_FULL;
              state_r              <= S_IDLE;
            end else begin
              out_r.status         <= ST_OK;
              out_r.granted_offset <= res_r.start;
              state_r              <= S_IDLE;
              if (do_split) count_r <= count_r + 1'b1;
            end
          end
        end
        S_MERGE_NEXT: begin
          if (res_r.next_free) count_r <= count_r - 1'b1;
          state_r <= S_MERGE_PREV;
        end
        S_MERGE_PREV: begin
          if (res_r.prev_free) count_r <= count_r - 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "best_fit_heap_allocator_core_assert.svh"

  `BFHA_ASSERT(a_count_range, clk, rst_n, (count_r != '0) && (count_r <= CW'(MAX_SEGMENTS)))
  `BFHA_ASSERT_NEXT(a_split_grows, clk, rst_n, do_split, count_r == $past(count_r) + 1'b1)
  `BFHA_ASSERT_NEXT(a_exec_result, clk, rst_n, (state_r == S_EXEC) && go, out_valid_r)

endmodule

/* rtl/bfha_cell.sv */
// ---------------------------------------------------------------------------
// bfha_cell
// One segment entry: applies broadcast edits and passes the scan token on.
// ---------------------------------------------------------------------------
module bfha_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bfha_pkg::cmd_t   cmd,
  input  logic [IW-1:0]    cmd_idx,
  input  bfha_pkg::scan_t  scan,
  input  bfha_pkg::seg_t   left,
  input  bfha_pkg::seg_t   right,
  input  bfha_pkg::tok_t   tok_in,
  input  logic [IW-1:0]    tok_idx_in,
  output bfha_pkg::seg_t   seg_q,
  output bfha_pkg::tok_t   tok_out,
  output logic [IW-1:0]    tok_idx_out
);
  import bfha_pkg::*;

  localparam logic [IW:0] ME = (IW+1)'(IDX);

  seg_t          seg_r, seg_nxt;
  tok_t          tok_r, tok_nxt;
  logic [IW-1:0] tidx_r, tidx_nxt;
  logic [IW:0]   k, k1;
  logic          hit;

  assign k  = {1'b0, cmd_idx};
  assign k1 = k + 1'b1;

  always_comb begin
    seg_nxt = seg_r;
    case (cmd.op)
      CMD_SPLIT: begin
        if (ME == k) begin
          seg_nxt.len  = cmd.size;
          seg_nxt.used = 1'b1;
        end else if (ME == k1) begin
          seg_nxt.valid = 1'b1;
          seg_nxt.used  = 1'b0;
          seg_nxt.start = left.start + cmd.size[OFF_W-1:0];
          seg_nxt.len   = left.len - cmd.size;
        end else if (ME > k1) begin
          seg_nxt = left;
        end
      end
      CMD_MARK:  if (ME == k) seg_nxt.used = 1'b1;
      CMD_CLEAR: if (ME == k) seg_nxt.used = 1'b0;
      CMD_MERGE: begin
        if (ME == k) seg_nxt.len = seg_r.len + right.len;
        else if (ME > k) seg_nxt = right;
      end
      default: seg_nxt = seg_r;
    endcase
  end

  // advance the scan token by one entry
  always_comb begin
    tok_nxt  = tok_in;
    tidx_nxt = tok_idx_in;
    if (scan.action == ACT_ALLOC) begin
      hit = seg_r.valid && !seg_r.used && (seg_r.len >= scan.size) &&
            (!tok_in.found || (seg_r.len < tok_in.len));
    end else begin
      hit = !tok_in.found && seg_r.valid && (seg_r.start == scan.offset);
    end
    if (hit) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.len       = seg_r.len;
      tok_nxt.start     = seg_r.start;
      tok_nxt.prev_free = left.valid && !left.used;
      tok_nxt.next_free = right.valid && !right.used;
      tidx_nxt          = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if (IDX == 0) begin
        seg_r <= '{valid: 1'b1, used: 1'b0, start: '0, len: LEN_W'(HEAP_BYTES)};
      end else begin
        seg_r <= '0;
      end
    end else begin
      seg_r <= seg_nxt;
    end
    tok_r  <= tok_nxt;
    tidx_r <= tidx_nxt;
  end

  assign seg_q       = seg_r;
  assign tok_out     = tok_r;
  assign tok_idx_out = tidx_r;

endmodule

/* sim/best_fit_heap_allocator_core_checker.sv */
// ---------------------------------------------------------------------------
// Allocator result checker
// Watches both channels, keeps its own copy of the segment table and
// compares every result item with the oldest expected one.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_core_checker #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bfha_pkg::bfha_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  bfha_pkg::bfha_out_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfha_pkg::*;

  logic [OFF_W-1:0] seg_start [MAX_SEGMENTS];
  logic [LEN_W-1:0] seg_len [MAX_SEGMENTS];
  logic             seg_used [MAX_SEGMENTS];
  int               seg_count;
  bfha_out_t        expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void table_reset();
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_start[i] = '0;
      seg_len[i] = '0;
      seg_used[i] = 1'b0;
    end
    seg_len[0] = LEN_W'(HEAP_BYTES);
    seg_count = 1;
  endfunction

  function automatic void join_free_runs();
    int w;
    w = 0;
    for (int r = 0; r < seg_count; r++) begin
      if (w > 0 && !seg_used[w-1] && !seg_used[r]) begin
        seg_len[w-1] += seg_len[r];
      end else begin
        seg_start[w] = seg_start[r];
        seg_len[w] = seg_len[r];
        seg_used[w] = seg_used[r];
        w++;
      end
    end
    for (int r = w; r < MAX_SEGMENTS; r++) begin
      seg_start[r] = '0;
      seg_len[r] = '0;
      seg_used[r] = 1'b0;
    end
    seg_count = w;
  endfunction

  function automatic bfha_out_t predict_request(input bfha_in_t req);
    bfha_out_t res;
    int best;
    res = '0;
    best = -1;
    if (req.action == ACT_ALLOC) begin
      if (req.request_size == 0) begin
        res.status = ST_ZERO;
        return res;
      end
      for (int i = 0; i < seg_count; i++) begin
        if (!seg_used[i] && seg_len[i] >= req.request_size &&
            (best < 0 || seg_len[i] < seg_len[best])) best = i;
      end
      if (best < 0) begin
        res.status = ST_NO_FIT;
        return res;
      end
      if (seg_len[best] > req.request_size) begin
        if (seg_count >= MAX_SEGMENTS) begin
          res.status = ST_FULL;
          return res;
        end
        for (int i = seg_count; i > best + 1; i--) begin
          seg_start[i] = seg_start[i-1];
          seg_len[i] = seg_len[i-1];
          seg_used[i] = seg_used[i-1];
        end
        seg_start[best+1] = seg_start[best] + OFF_W'(req.request_size);
        seg_len[best+1] = seg_len[best] - req.request_size;
        seg_used[best+1] = 1'b0;
        seg_len[best] = req.request_size;
        seg_count++;
      end
      seg_used[best] = 1'b1;
      res.granted_offset = seg_start[best];
      res.status = ST_OK;
    end else begin
      res.status = ST_NONE;
      for (int i = 0; i < seg_count; i++) begin
        if (seg_start[i] == req.block_offset) begin
          seg_used[i] = 1'b0;
          join_free_runs();
          res.status = ST_OK;
          break;
        end
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    table_reset();
  end

  always @(posedge clk) begin
    bfha_out_t exp_item;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_q.push_back(predict_request(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.granted_offset !== exp_item.granted_offset)
            report($sformatf("granted_offset %0d, expected %0d",
                             out_data.granted_offset, exp_item.granted_offset));
          if (out_data.status !== exp_item.status)
            report($sformatf("status %0d, expected %0d",
                             out_data.status, exp_item.status));
        end
      end
    end
  end
endmodule

/* sim/best_fit_heap_allocator_core_test.sv */
// ---------------------------------------------------------------------------
// Allocator testbench top
// Drives allocate and free requests through the core with random idling
// on both channels; a checker beside the core predicts every result.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfha_pkg::*;

  localparam int MAX_SEGMENTS = 64;
  localparam int RANDOM_ITEMS = 1807;
  // Worst idle cycles: a full token walk plus long stalls, many times over.
  localparam int IDLE_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  bfha_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  bfha_out_t out_data;
  int        fail_count;
  int        pending_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        idle_cycles;
  // Offsets handed out so far, so that most frees hit a live block.
  logic [OFF_W-1:0] live_offsets[$];

  best_fit_heap_allocator_core #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  best_fit_heap_allocator_core_checker #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls are redrawn every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Track granted offsets so that frees mostly name real blocks.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_data.status == ST_OK &&
        out_data.granted_offset != 0)
      live_offsets.push_back(out_data.granted_offset);
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one item and hold it until it is accepted; idle beforehand.
  task automatic send_item(input logic act, input logic [LEN_W-1:0] size,
                           input logic [OFF_W-1:0] offset);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.action <= act;
    in_data.request_size <= size;
    in_data.block_offset <= offset;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int pick;
    logic [OFF_W-1:0] offs;
    int idx;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // Mostly small sizes so the table fills and splits often.
      if ($urandom_range(9) < 8) send_item(ACT_ALLOC, LEN_W'($urandom_range(1, 200)), OFF_W'($urandom));
      else send_item(ACT_ALLOC, LEN_W'($urandom_range(0, 8191)), OFF_W'($urandom));
    end else if (pick < 88 && live_offsets.size() > 0) begin
      idx = $urandom_range(live_offsets.size() - 1);
      offs = live_offsets[idx];
      live_offsets.delete(idx);
      send_item(ACT_FREE, LEN_W'($urandom), offs);
    end else begin
      // Noise: a free at an arbitrary offset, often no segment there.
      send_item(ACT_FREE, LEN_W'($urandom), OFF_W'($urandom));
    end
  endtask

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 49;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero size, oversized, whole heap, frees of all kinds.
    send_item(ACT_ALLOC, '0, '0);
    send_item(ACT_ALLOC, 13'd8191, 12'hfff);
    send_item(ACT_ALLOC, 13'd4097, '0);
    send_item(ACT_ALLOC, 13'd4096, '0);
    send_item(ACT_ALLOC, 13'd1, '0);
    send_item(ACT_FREE, '0, 12'hfff);
    send_item(ACT_FREE, 13'h1fff, '0);
    send_item(ACT_FREE, '0, '0);
    send_item(ACT_ALLOC, 13'd1, '0);
    send_item(ACT_ALLOC, 13'd4095, '0);
    send_item(ACT_FREE, '0, '0);
    send_item(ACT_FREE, '0, 12'd1);
    // Fill the table with unit blocks so splits hit the table-full case.
    for (int i = 0; i < MAX_SEGMENTS; i++) send_item(ACT_ALLOC, 13'd1, '0);
    // Exact fit into the last free segment while full, then free it again.
    send_item(ACT_ALLOC, 13'd4033, '0);
    send_item(ACT_FREE, '0, 12'd63);
    send_item(ACT_ALLOC, 13'd4032, '0);
    for (int i = 0; i < 64; i++) send_item(ACT_FREE, '0, OFF_W'(i));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 13;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (MAX_SEGMENTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
